// ----- hw/rtl/bpfa_pkg.sv -----
`timescale 1ns / 1ps
package bpfa_pkg;
	localparam int unsigned PagesDef = 65536;
	localparam int unsigned MegaPagesDef = 512;
	localparam int unsigned CntW = 17;
	localparam logic [CntW-1:0] CountMax = '1;

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_MALLOC = 2'd1,
		FN_FREE = 2'd2,
		FN_MFREE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO = 2'd1,
		ST_NOFREE = 2'd2,
		ST_NORUN = 2'd3
	} status_t;
endpackage

// ----- hw/rtl/bitmap_page_frame_allocator_unit.sv -----
`timescale 1ns / 1ps
// channel   | ports                              | transfer
// ----------+------------------------------------+---------------------------
// request   | start, busy, func, start_page,     | start high, busy low
//           | count                              |
// result    | done, status, page_index,          | one cycle, done high
//           | free_pages                         |
// config    | psel penable pwrite paddr pwdata   | access phase, pready high
//
// The map is a memory of 32-bit words, one read or write per cycle. A search
// scans one page per cycle below the page limit; marking or clearing a run
// reads each touched word and then writes it back.
// Reset sets every page used: a clearing pass writes all ones to every word
// and keeps busy high meanwhile. Results cannot be stalled.
module bitmap_page_frame_allocator_unit #(
	parameter int unsigned PAGES = bpfa_pkg::PagesDef,
	parameter int unsigned MEGA_PAGES = bpfa_pkg::MegaPagesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] func,
	input  logic [15:0] start_page,
	input  logic [16:0] count,
	output logic done,
	output logic [1:0] status,
	output logic [15:0] page_index,
	output logic [16:0] free_pages,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [0:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bpfa_pkg::*;

	localparam int unsigned Words = (PAGES + 31) / 32;
	localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1;
	localparam int unsigned PW = $clog2(PAGES) + 1;
	localparam int unsigned MW = (MEGA_PAGES > 1) ? $clog2(MEGA_PAGES) : 1;
	localparam logic [PW-1:0] PagesP = PW'(PAGES);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SRD, S_SCAN, S_WRD, S_WMOD, S_DONE
	} state_t;

	logic [31:0] mem [Words];
	logic [31:0] rd_q;
	logic [AW-1:0] raddr;
	logic re;
	logic we;
	logic [AW-1:0] waddr;
	logic [31:0] wdata;

	state_t state_q;
	logic [16:0] total_q;
	logic [CntW-1:0] free_q;
	logic [PW-1:0] p_q;      // current page
	logic [PW-1:0] run_q;
	logic [PW-1:0] end_q;    // write end (exclusive)
	logic [PW-1:0] lim_q;
	logic [PW+1:0] need_q;
	logic align_q;
	logic set_q;
	logic [PW-1:0] s_q;
	logic [1:0] st_q;
	logic [16:0] addn_q;
	logic [AW-1:0] clr_q;
	logic [MW-1:0] pm_q;     // (current page + 1) modulo MEGA_PAGES

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {15'd0, total_q} : 32'd0;
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	logic [PW-1:0] lim_c;
	always_comb begin
		lim_c = (32'(total_q) > PAGES) ? PagesP : PW'(total_q);
	end

	logic [33:0] fend_c;
	assign fend_c = 34'(start_page) + 34'((func == FN_FREE) ? count : 17'(MEGA_PAGES));

	logic bit_c;
	logic [PW-1:0] run_n;
	logic [PW+1:0] scand;
	logic [PW-1:0] cand;
	assign bit_c = rd_q[p_q[4:0]];
	assign run_n = run_q + 1'b1;
	assign scand = (PW+2)'(p_q) + 1'b1 - need_q;
	assign cand = scand[PW-1:0];

	logic [31:0] mask_c;
	always_comb begin
		for (int i = 0; i < 32; i++)
			mask_c[i] = ({p_q[PW-1:5], 5'(i)} >= p_q) &&
				({p_q[PW-1:5], 5'(i)} < end_q);
	end

	always_comb begin
		re = 1'b0;
		raddr = p_q[AW+4:5];
		we = 1'b0;
		waddr = p_q[AW+4:5];
		wdata = set_q ? (rd_q | mask_c) : (rd_q & ~mask_c);
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '1;
			end
			S_SRD, S_WRD: re = 1'b1;
			S_SCAN: re = (p_q[4:0] == 5'd31);
			S_WMOD: we = 1'b1;
			default: ;
		endcase
		if (state_q == S_SCAN) raddr = AW'((p_q + 1'b1) >> 5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			total_q <= 17'd65536;
			free_q <= '0;
			clr_q <= '0;
			done <= 1'b0;
			status <= ST_OK;
			page_index <= '0;
			free_pages <= '0;
		end else begin
			done <= 1'b0;
			if (psel && penable && pwrite && paddr == 1'b0) total_q <= pwdata[16:0];
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(Words - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					p_q <= '0;
					run_q <= '0;
					pm_q <= MW'(1);
					lim_q <= lim_c;
					st_q <= ST_OK;
					s_q <= '0;
					if (func == FN_FREE || func == FN_MFREE) begin
						addn_q <= (func == FN_FREE) ? count : 17'(MEGA_PAGES);
						set_q <= 1'b0;
						p_q <= PW'(start_page);
						if (fend_c > 34'(PAGES))
							end_q <= PagesP;
						else
							end_q <= PW'(fend_c);
						if (32'(start_page) >= PAGES || (func == FN_FREE &&
							count == 0)) state_q <= S_DONE;
						else state_q <= S_WRD;
					end else begin
						addn_q <= '0;
						set_q <= 1'b1;
						align_q <= (func == FN_MALLOC);
						need_q <= (func == FN_MALLOC) ?
							(PW+2)'(34'(count) * 34'(MEGA_PAGES)) : (PW+2)'(count);
						if (count == 0) begin
							st_q <= ST_ZERO;
							state_q <= S_DONE;
						end else if (((func == FN_MALLOC) ? 34'(count) * 34'(MEGA_PAGES)
							: 34'(count)) > 34'(free_q)) begin
							st_q <= ST_NOFREE;
							state_q <= S_DONE;
						end else if (lim_c == 0) begin
							st_q <= ST_NORUN;
							state_q <= S_DONE;
						end else state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SCAN;
				S_SCAN: begin
					if (bit_c) run_q <= '0;
					else run_q <= run_n;
					if (!bit_c && (PW+2)'(run_n) >= need_q &&
						(!align_q || pm_q == '0)) begin
						s_q <= cand;
						end_q <= p_q + 1'b1;
						p_q <= cand;
						state_q <= S_WRD;
					end else if (p_q + 1'b1 >= lim_q) begin
						st_q <= ST_NORUN;
						state_q <= S_DONE;
					end else begin
						p_q <= p_q + 1'b1;
						pm_q <= (pm_q == MW'(MEGA_PAGES - 1)) ? '0 : pm_q + 1'b1;
					end
				end
				S_WRD: state_q <= S_WMOD;
				S_WMOD: begin
					if ({p_q[PW-1:5], 5'd0} + PW'(32) >= end_q) state_q <= S_DONE;
					else begin
						p_q <= {p_q[PW-1:5], 5'd0} + PW'(32);
						state_q <= S_WRD;
					end
				end
				S_DONE: begin
					logic [CntW:0] sum;
					sum = {1'b0, free_q} + {1'b0, addn_q};
					done <= 1'b1;
					status <= st_q;
					page_index <= (st_q == ST_OK && set_q) ? 16'(s_q) : 16'd0;
					if (st_q == ST_OK && set_q) begin
						free_q <= free_q - CntW'(need_q);
						free_pages <= free_q - CntW'(need_q);
					end else if (!set_q) begin
						free_q <= sum[CntW] ? CountMax : sum[CntW-1:0];
						free_pages <= sum[CntW] ? CountMax : sum[CntW-1:0];
					end else free_pages <= free_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
